// ===== src/mnmg_pkg.sv =====
// shared types, constants and saturation helper for the midi note message generator
// no dependencies; compiled first

package mnmg_pkg;

	localparam int SLOTS   = 16;
	localparam int IDX_W   = 4;
	localparam int COUNT_W = 5;
	localparam int RAW_W   = 11;
	localparam int MSG_MAX = 3;
	localparam int NUM_W   = 2;

	// saturation limits
	localparam logic [6:0] NOTE_MAX    = 7'd127;
	localparam logic [6:0] VOLUME_MAX  = 7'd127;
	localparam logic [6:0] VOICE_MAX   = 7'd126;
	localparam logic [6:0] CHANNEL_MAX = 7'd8;

	// status byte bases
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_PROGRAM  = 8'hC0;

	typedef enum logic [1:0] {
		EDGE_NONE = 2'd0,
		EDGE_RISE = 2'd1,
		EDGE_FALL = 2'd2
	} edge_kind_t;

	typedef struct packed {
		logic                       trigger_level;
		logic                       first_slot;
		logic [IDX_W-1:0]           slot_index;
		logic [COUNT_W-1:0]         slot_count;
		logic signed [RAW_W-1:0]    note_raw;
		logic signed [RAW_W-1:0]    volume_raw;
		logic signed [RAW_W-1:0]    voice_raw;
		logic signed [RAW_W-1:0]    channel_raw;
	} slot_item_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
	} midi_msg_t;

	typedef struct packed {
		logic [NUM_W-1:0]            num;
		midi_msg_t [MSG_MAX-1:0]     msg;
	} msg_set_t;

	typedef struct packed {
		logic       valid;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [3:0] channel;
	} slot_entry_t;

	// view of stored state for the current slot
	typedef struct packed {
		logic               trigger;
		edge_kind_t         edge_kind;
		logic [COUNT_W-1:0] stored_count;
		slot_entry_t        entry;
	} store_view_t;

	// state changes caused by one transaction
	typedef struct packed {
		logic               trig_we;
		logic               trig_d;
		logic               edge_we;
		edge_kind_t         edge_d;
		logic               count_we;
		logic [COUNT_W-1:0] count_d;
		logic               clear_all;
		logic               entry_we;
		slot_entry_t        entry_d;
	} store_update_t;

	// clamp a signed raw value to 0..hi
	function automatic logic [6:0] sat_u7(input logic signed [RAW_W-1:0] raw,
		input logic [6:0] hi);
		logic signed [RAW_W-1:0] hi_s;
		logic [6:0]              res;
		hi_s = signed'({{(RAW_W-7){1'b0}}, hi});
		if (raw < 0) begin
			res = 7'd0;
		end else if (raw > hi_s) begin
			res = hi;
		end else begin
			res = raw[6:0];
		end
		return res;
	endfunction

endpackage

// ===== src/mnmg_if.sv =====
// valid/ready channel interfaces for slot items and midi messages
// depends on mnmg_pkg for field widths

interface mnmg_slot_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 trigger_level;
	logic                                 first_slot;
	logic [mnmg_pkg::IDX_W-1:0]           slot_index;
	logic [mnmg_pkg::COUNT_W-1:0]         slot_count;
	logic signed [mnmg_pkg::RAW_W-1:0]    note_raw;
	logic signed [mnmg_pkg::RAW_W-1:0]    volume_raw;
	logic signed [mnmg_pkg::RAW_W-1:0]    voice_raw;
	logic signed [mnmg_pkg::RAW_W-1:0]    channel_raw;

	modport source (
		output valid, trigger_level, first_slot, slot_index, slot_count,
			note_raw, volume_raw, voice_raw, channel_raw,
		input  ready
	);
	modport sink (
		input  valid, trigger_level, first_slot, slot_index, slot_count,
			note_raw, volume_raw, voice_raw, channel_raw,
		output ready
	);
endinterface

interface mnmg_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	logic [6:0] first_data;
	logic [6:0] second_data;
	logic       last_message;

	modport source (
		output valid, status_byte, first_data, second_data, last_message,
		input  ready
	);
	modport sink (
		input  valid, status_byte, first_data, second_data, last_message,
		output ready
	);
endinterface

// ===== src/mnmg_decode.sv =====
// edge detection, saturation and message formation for one slot transaction
// depends on mnmg_pkg; purely combinational

module mnmg_decode (
	input  mnmg_pkg::slot_item_t    item,
	input  mnmg_pkg::store_view_t   view,
	output mnmg_pkg::store_update_t upd,
	output mnmg_pkg::msg_set_t      msgs
);
	import mnmg_pkg::*;

	logic [COUNT_W-1:0] count_raw;
	logic [COUNT_W-1:0] count_c;
	logic               count_ok;
	edge_kind_t         edge_new;
	logic               in_range;
	logic               active;
	logic [6:0]         note;
	logic [6:0]         vol;
	logic [6:0]         voice;
	logic [6:0]         ch7;
	logic [3:0]         ch;
	logic               old_valid;
	midi_msg_t          m_off_old;
	midi_msg_t          m_prog;
	midi_msg_t          m_on;
	midi_msg_t          m_off_new;

	// slot count clamp and pass edge
	always_comb begin
		count_raw = item.slot_count;
		count_ok  = (count_raw != '0);
		count_c   = (count_raw > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : count_raw;
		if (item.first_slot) begin
			if (item.trigger_level) begin
				edge_new = view.trigger ? EDGE_NONE : EDGE_RISE;
			end else begin
				edge_new = view.trigger ? EDGE_FALL : EDGE_NONE;
			end
		end else begin
			edge_new = view.edge_kind;
		end
		in_range = ({1'b0, item.slot_index} < count_c);
		active   = count_ok && in_range && (edge_new != EDGE_NONE);
	end

	// saturated values
	always_comb begin
		note  = sat_u7(item.note_raw, NOTE_MAX);
		vol   = sat_u7(item.volume_raw, VOLUME_MAX);
		voice = sat_u7(item.voice_raw, VOICE_MAX);
		ch7   = sat_u7(item.channel_raw, CHANNEL_MAX);
		ch    = ch7[3:0];
	end

	// candidate messages
	always_comb begin
		m_off_old = '{status: ST_NOTE_OFF | {4'd0, view.entry.channel},
			d1: view.entry.note, d2: view.entry.velocity};
		m_prog    = '{status: ST_PROGRAM | {4'd0, ch}, d1: voice, d2: 7'd0};
		m_on      = '{status: ST_NOTE_ON | {4'd0, ch}, d1: note, d2: vol};
		m_off_new = '{status: ST_NOTE_OFF | {4'd0, ch}, d1: note, d2: vol};
	end

	// state update and message set
	always_comb begin
		upd           = '0;
		upd.trig_we   = count_ok && item.first_slot;
		upd.trig_d    = item.trigger_level;
		upd.edge_we   = count_ok && item.first_slot;
		upd.edge_d    = edge_new;
		upd.count_d   = count_c;
		upd.entry_d   = '{valid: 1'b1, note: note, velocity: vol, channel: ch};
		old_valid     = 1'b0;
		msgs          = '0;
		if (active && (edge_new == EDGE_RISE)) begin
			upd.clear_all = (count_c != view.stored_count);
			upd.count_we  = upd.clear_all;
			upd.entry_we  = 1'b1;
			old_valid     = view.entry.valid && !upd.clear_all;
			if (old_valid) begin
				msgs.num    = NUM_W'(3);
				msgs.msg[0] = m_off_old;
				msgs.msg[1] = m_prog;
				msgs.msg[2] = m_on;
			end else begin
				msgs.num    = NUM_W'(2);
				msgs.msg[0] = m_prog;
				msgs.msg[1] = m_on;
			end
		end else if (active) begin
			upd.entry_we      = ({1'b0, item.slot_index} < view.stored_count);
			upd.entry_d.valid = 1'b0;
			msgs.num          = NUM_W'(1);
			msgs.msg[0]       = m_off_new;
		end
	end

endmodule

// ===== src/mnmg_slot_store.sv =====
// trigger memory, pass edge, stored slot count and per-slot note store
// depends on mnmg_pkg

module mnmg_slot_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [mnmg_pkg::IDX_W-1:0]  idx,
	input  mnmg_pkg::store_update_t     upd,
	output mnmg_pkg::store_view_t       view
);
	import mnmg_pkg::*;

	logic               trigger_q;
	edge_kind_t         edge_q;
	logic [COUNT_W-1:0] count_q;
	logic [SLOTS-1:0]   valid_q;
	logic [6:0]         note_q  [SLOTS];
	logic [6:0]         vel_q   [SLOTS];
	logic [3:0]         chan_q  [SLOTS];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= 1'b0;
			edge_q    <= EDGE_NONE;
			count_q   <= '0;
			valid_q   <= '0;
		end else if (take) begin
			if (upd.trig_we) begin
				trigger_q <= upd.trig_d;
			end
			if (upd.edge_we) begin
				edge_q <= upd.edge_d;
			end
			if (upd.count_we) begin
				count_q <= upd.count_d;
			end
			if (upd.clear_all || upd.entry_we) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (upd.entry_we && (idx == IDX_W'(i))) begin
						valid_q[i] <= upd.entry_d.valid;
					end else if (upd.clear_all) begin
						valid_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	// slot payload, written only when a note is stored
	always_ff @(posedge clk) begin
		if (take && upd.entry_we && upd.entry_d.valid) begin
			note_q[idx] <= upd.entry_d.note;
			vel_q[idx]  <= upd.entry_d.velocity;
			chan_q[idx] <= upd.entry_d.channel;
		end
	end

	// read view for the current slot
	always_comb begin
		view.trigger        = trigger_q;
		view.edge_kind      = edge_q;
		view.stored_count   = count_q;
		view.entry.valid    = valid_q[idx];
		view.entry.note     = note_q[idx];
		view.entry.velocity = vel_q[idx];
		view.entry.channel  = chan_q[idx];
	end

endmodule

// ===== src/mnmg_msg_queue.sv =====
// result register holding up to three messages, drained one per transaction
// depends on mnmg_pkg

module mnmg_msg_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  mnmg_pkg::msg_set_t    msgs,
	output logic                  can_load,
	mnmg_msg_if.source            msg
);
	import mnmg_pkg::*;

	logic [NUM_W-1:0]        cnt_q;
	midi_msg_t [MSG_MAX-1:0] msg_q;
	logic                    pop;

	assign pop      = msg.valid && msg.ready;
	// queue empties by the end of this cycle
	assign can_load = (cnt_q == '0) || ((cnt_q == NUM_W'(1)) && msg.ready);

	// message count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= msgs.num;
		end else if (pop) begin
			cnt_q <= cnt_q - NUM_W'(1);
		end
	end

	// message payload, head at index zero
	always_ff @(posedge clk) begin
		if (load) begin
			msg_q <= msgs.msg;
		end else if (pop) begin
			for (int i = 0; i < MSG_MAX - 1; i++) begin
				msg_q[i] <= msg_q[i+1];
			end
		end
	end

	// output channel
	always_comb begin
		msg.valid        = (cnt_q != '0);
		msg.status_byte  = msg_q[0].status;
		msg.first_data   = msg_q[0].d1;
		msg.second_data  = msg_q[0].d2;
		msg.last_message = (cnt_q == NUM_W'(1));
	end

endmodule

// ===== src/midi_note_message_generator.sv =====
// midi note message generator: slot transactions in, note/program messages out
// output: the first message of a transaction is valid the cycle after acceptance
// a transaction causing n messages (0..3) presents them one at a time, each held until taken;
//   the next transaction is taken in the cycle the last message drains
// reset: clears trigger memory, edge, stored slot count, slot valid bits and message queue
// depends on mnmg_pkg, mnmg_if, mnmg_decode, mnmg_slot_store, mnmg_msg_queue

module midi_note_message_generator (
	input  logic       clk,
	input  logic       arst_n,
	mnmg_slot_if.sink  slot_item,
	mnmg_msg_if.source midi_msg
);
	import mnmg_pkg::*;

	slot_item_t    item;
	store_view_t   view;
	store_update_t upd;
	msg_set_t      msgs;
	logic          can_load;
	logic          take;

	// pack incoming transaction
	always_comb begin
		item.trigger_level = slot_item.trigger_level;
		item.first_slot    = slot_item.first_slot;
		item.slot_index    = slot_item.slot_index;
		item.slot_count    = slot_item.slot_count;
		item.note_raw      = slot_item.note_raw;
		item.volume_raw    = slot_item.volume_raw;
		item.voice_raw     = slot_item.voice_raw;
		item.channel_raw   = slot_item.channel_raw;
	end

	// input handshake
	assign slot_item.ready = can_load;
	assign take            = slot_item.valid && can_load;

	mnmg_decode u_decode (
		.item (item),
		.view (view),
		.upd  (upd),
		.msgs (msgs)
	);

	mnmg_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.idx    (item.slot_index),
		.upd    (upd),
		.view   (view)
	);

	mnmg_msg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.msgs     (msgs),
		.can_load (can_load),
		.msg      (midi_msg)
	);

endmodule
